// File: rtl/strict_priority_multi_fifo_assert.svh
// ----------------------------------------------------------------------------
// Strict priority multi FIFO assertion macros
// Shared property macros, sampled on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef STRICT_PRIORITY_MULTI_FIFO_ASSERT_SVH
`define STRICT_PRIORITY_MULTI_FIFO_ASSERT_SVH

// same-cycle implication
`define SPMF_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("spmf: property failed");

// next-cycle implication
`define SPMF_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("spmf: property failed");

`endif

// File: rtl/spmf_pkg.sv
// ----------------------------------------------------------------------------
// Strict priority multi FIFO package
// Field widths, codes, defaults and the structs passed between the parts.
// ----------------------------------------------------------------------------
package spmf_pkg;

  localparam int LEVELS_DEF      = 8;
  localparam int LEVEL_DEPTH_DEF = 16;
  localparam int ITEM_BITS_DEF   = 32;

  localparam int ITEM_W   = 32;
  localparam int PRIO_W   = 3;
  localparam int STATUS_W = 2;

  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // queued request, classified by the front part
  typedef struct packed {
    logic              op;
    logic [ITEM_W-1:0] item;
    logic [PRIO_W-1:0] prio;
    logic              drop;   // level outside the configured range
  } req_t;

  // result fields handed to the output stream
  typedef struct packed {
    status_t           status;
    logic [ITEM_W-1:0] out_item;
    logic [PRIO_W-1:0] top_level;
    logic [ITEM_W-1:0] head_item;
    logic              all_empty;
  } res_t;

endpackage

// File: rtl/strict_priority_multi_fifo.sv
// Steps: an accepted request goes to head read (a remove that finds an item via pop wait),
// to head wait if a level still holds an item, then to the result state and output register.
// The back end takes the next request only in idle, set by the single read port of
// the item store (pop read, then head read); a stalled result holds it in the result state.
// A 2-entry input queue and the output register let both sides stall independently.
// Reset (rst, synchronous) clears level counts and read pointers; the store is not cleared.
// ----------------------------------------------------------------------------
// Strict priority multi FIFO
// One FIFO per priority level in a shared item store; remove serves the
// highest non-empty level. Every result reports the new top level state.
// ----------------------------------------------------------------------------
module strict_priority_multi_fifo #(
  parameter int LEVELS      = spmf_pkg::LEVELS_DEF,
  parameter int LEVEL_DEPTH = spmf_pkg::LEVEL_DEPTH_DEF,
  parameter int ITEM_BITS   = spmf_pkg::ITEM_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // item[31:0], priority_req[34:32], zero pad
  input  logic        s_tuser,   // func: 0 add, 1 remove
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // out_item[31:0], top_level[34:32],
                                 // head_item[66:35], all_empty[67], zero pad
  output logic [1:0]  m_tuser    // status: 0 ok, 1 add dropped, 2 remove on empty
);

  logic           q_valid;
  logic           q_take;
  spmf_pkg::req_t q_entry;
  spmf_pkg::res_t res;

  // front: accept, flag add levels at or above LEVELS as drops, queue
  spmf_front #(
    .LEVELS (LEVELS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_func  (s_tuser),
    .in_item  (s_tdata[31:0]),
    .in_prio  (s_tdata[34:32]),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_take   (q_take)
  );

  // back: level bookkeeping, item store, result register
  spmf_back #(
    .LEVELS      (LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .ITEM_BITS   (ITEM_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_take    (q_take),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // result packing, lowest field first
  assign m_tdata = {4'd0, res.all_empty, res.head_item, res.top_level, res.out_item};
  assign m_tuser = res.status;

endmodule

// File: rtl/spmf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module spmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/spmf_front.sv
// ----------------------------------------------------------------------------
// Strict priority multi FIFO front part
// Accepts items, flags out-of-range levels, holds them in a 2-entry queue.
// ----------------------------------------------------------------------------
module spmf_front #(
  parameter int LEVELS = spmf_pkg::LEVELS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_func,
  input  logic [spmf_pkg::ITEM_W-1:0]           in_item,
  input  logic [spmf_pkg::PRIO_W-1:0]           in_prio,
  output logic                                  q_valid,
  output spmf_pkg::req_t                        q_entry,
  input  logic                                  q_take
);

  spmf_pkg::req_t q_mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     q_cnt;
  logic           push;
  logic           pop;
  spmf_pkg::req_t req_in;

  assign in_ready = (q_cnt != 2'd2);
  assign q_valid  = (q_cnt != 2'd0);
  assign push     = in_valid & in_ready;
  assign pop      = q_take & q_valid;
  assign q_entry  = q_mem[rd_ptr];

  always_comb begin
    req_in.op   = in_func;
    req_in.item = in_item;
    req_in.prio = in_prio;
    req_in.drop = (in_func == spmf_pkg::FUNC_ADD) && (32'(in_prio) >= 32'(LEVELS));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= req_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      q_cnt  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   q_cnt <= q_cnt + 2'd1;
        2'b01:   q_cnt <= q_cnt - 2'd1;
        default: q_cnt <= q_cnt;
      endcase
    end
  end

endmodule

// File: rtl/spmf_back.sv
// ----------------------------------------------------------------------------
// Strict priority multi FIFO back part
// Per-level head/count state, item store, sequencer and result register.
// ----------------------------------------------------------------------------
`include "strict_priority_multi_fifo_assert.svh"

module spmf_back #(
  parameter int LEVELS      = spmf_pkg::LEVELS_DEF,
  parameter int LEVEL_DEPTH = spmf_pkg::LEVEL_DEPTH_DEF,
  parameter int ITEM_BITS   = spmf_pkg::ITEM_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  spmf_pkg::req_t q_entry,
  output logic           q_take,
  output logic           out_valid,
  input  logic           out_ready,
  output spmf_pkg::res_t out_res
);

  localparam int LW = $clog2(LEVELS);
  localparam int HW = $clog2(LEVEL_DEPTH);
  localparam int CW = $clog2(LEVEL_DEPTH + 1);
  localparam int SW = (ITEM_BITS < spmf_pkg::ITEM_W) ? ITEM_BITS : spmf_pkg::ITEM_W;
  localparam int MD = LEVELS * LEVEL_DEPTH;
  localparam int AW = $clog2(MD);
  localparam int PW = spmf_pkg::PRIO_W;
  localparam int IW = spmf_pkg::ITEM_W;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_POPWAIT  = 6'b000010,
    S_HEADRD   = 6'b000100,
    S_HEADWAIT = 6'b001000,
    S_RESULT   = 6'b010000,
    S_SPARE    = 6'b100000
  } state_t;

  state_t            state;
  state_t            state_next;

  logic [CW-1:0]     cnt  [LEVELS];
  logic [HW-1:0]     head [LEVELS];

  logic [LW-1:0]     top_lv;
  logic              any_full;
  logic [LW-1:0]     sel_lv;
  logic [LW+PW-1:0]  prio_ext;
  logic [CW-1:0]     cnt_sel;
  logic [HW-1:0]     head_sel;
  logic [CW:0]       tail_sum;
  logic [HW-1:0]     tail_slot;
  logic [HW-1:0]     head_inc;
  logic [AW-1:0]     base_addr;

  logic              is_add;
  logic              add_ok;
  logic              pop_ok;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [SW-1:0]     ram_rdata;

  logic              cur_op;
  spmf_pkg::status_t res_status;
  logic [SW-1:0]     res_popped;
  logic [LW-1:0]     res_top;
  logic [SW-1:0]     res_head;
  logic              res_empty;

  logic [LW+PW-1:0]  top_ext;
  logic [SW+IW-1:0]  popped_ext;
  logic [SW+IW-1:0]  head_ext;

  // highest non-empty level; last hit of the ascending scan wins
  always_comb begin
    top_lv   = '0;
    any_full = 1'b0;
    for (int i = 0; i < LEVELS; i++) begin
      if (cnt[i] != '0) begin
        top_lv   = LW'(i);
        any_full = 1'b1;
      end
    end
  end

  assign is_add   = (q_entry.op == spmf_pkg::FUNC_ADD);
  assign prio_ext = {{LW{1'b0}}, q_entry.prio};
  // adds work on their own level, everything else on the top level
  assign sel_lv   = ((state == S_IDLE) && is_add) ? prio_ext[LW-1:0] : top_lv;
  assign cnt_sel  = cnt[sel_lv];
  assign head_sel = head[sel_lv];

  assign tail_sum  = (CW+1)'(head_sel) + (CW+1)'(cnt_sel);
  assign tail_slot = (tail_sum >= (CW+1)'(LEVEL_DEPTH))
                     ? HW'(tail_sum - (CW+1)'(LEVEL_DEPTH)) : HW'(tail_sum);
  assign head_inc  = (head_sel == HW'(LEVEL_DEPTH - 1)) ? '0 : head_sel + HW'(1);
  assign base_addr = AW'(AW'(sel_lv) * AW'(LEVEL_DEPTH));

  assign q_take = (state == S_IDLE) && q_valid;
  assign add_ok = q_take && is_add && !q_entry.drop && (cnt_sel != CW'(LEVEL_DEPTH));
  assign pop_ok = q_take && !is_add && any_full;

  assign ram_we    = add_ok;
  assign ram_waddr = base_addr + AW'(tail_slot);
  assign ram_re    = pop_ok || ((state == S_HEADRD) && any_full);
  assign ram_raddr = base_addr + AW'(head_sel);

  spmf_ram #(
    .WIDTH (SW),
    .DEPTH (MD)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_entry.item[SW-1:0]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // per-level counters and read pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        cnt[i]  <= '0;
        head[i] <= '0;
      end
    end else if (add_ok) begin
      cnt[sel_lv] <= cnt_sel + CW'(1);
    end else if (pop_ok) begin
      cnt[sel_lv]  <= cnt_sel - CW'(1);
      head[sel_lv] <= head_inc;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (pop_ok) begin
          state_next = S_POPWAIT;
        end else if (q_take) begin
          state_next = S_HEADRD;
        end
      end
      S_POPWAIT:  state_next = S_HEADRD;
      S_HEADRD:   state_next = any_full ? S_HEADWAIT : S_RESULT;
      S_HEADWAIT: state_next = S_RESULT;
      S_RESULT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_RESULT) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working result fields
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_take) begin
          cur_op     <= q_entry.op;
          res_popped <= '0;
          if (is_add) begin
            res_status <= add_ok ? spmf_pkg::ST_OK : spmf_pkg::ST_FULL;
          end else begin
            res_status <= any_full ? spmf_pkg::ST_OK : spmf_pkg::ST_EMPTY;
          end
        end
      end
      S_POPWAIT: res_popped <= ram_rdata;
      S_HEADRD: begin
        res_top   <= any_full ? top_lv : '0;
        res_empty <= !any_full;
        res_head  <= '0;
      end
      S_HEADWAIT: res_head <= ram_rdata;
      default: ;
    endcase
  end

  assign top_ext    = {{PW{1'b0}}, res_top};
  assign popped_ext = {{IW{1'b0}}, res_popped};
  assign head_ext   = {{IW{1'b0}}, res_head};

  always_ff @(posedge clk) begin
    if ((state == S_RESULT) && (!out_valid || out_ready)) begin
      out_res.status    <= res_status;
      out_res.out_item  <= popped_ext[IW-1:0];
      out_res.top_level <= top_ext[PW-1:0];
      out_res.head_item <= head_ext[IW-1:0];
      out_res.all_empty <= res_empty;
    end
  end

  `SPMF_ASSERT_IMP(a_cnt_bound, 1'b1, cnt[top_lv] <= CW'(LEVEL_DEPTH))
  `SPMF_ASSERT_NXT(a_pop_wait, pop_ok, state == S_POPWAIT)
  `SPMF_ASSERT_NXT(a_hold_result, (state == S_RESULT) && out_valid && !out_ready,
                   state == S_RESULT)
  `SPMF_ASSERT_IMP(a_full_is_add, (state == S_RESULT) && (res_status == spmf_pkg::ST_FULL),
                   cur_op == spmf_pkg::FUNC_ADD)
  `SPMF_ASSERT_IMP(a_empty_flag, (state == S_RESULT) && (res_status == spmf_pkg::ST_EMPTY),
                   res_empty && (res_popped == '0))

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Strict priority multi FIFO testbench
// Sends add and remove requests with random bursts, gaps and result-side
// stalls. A local per-level FIFO predictor gives each expected result, and
// every returned result is compared field by field with it.
// ----------------------------------------------------------------------------
module tb;

  localparam int LEVEL_CNT = spmf_pkg::LEVELS_DEF;
  localparam int DEPTH     = spmf_pkg::LEVEL_DEPTH_DEF;
  localparam int WORD_W    = spmf_pkg::ITEM_W;
  localparam int LVL_W     = spmf_pkg::PRIO_W;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [1:0]  m_tuser;

  strict_priority_multi_fifo u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // item[31:0], priority_req[34:32], zero pad
    .s_tuser  (s_tuser),   // func
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // out_item[31:0], top_level[34:32], head_item[66:35],
                           // all_empty[67], zero pad
    .m_tuser  (m_tuser)    // status
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Predicted queue contents: one circular slice per level
  logic [WORD_W-1:0] slot_word [LEVEL_CNT*DEPTH];
  int                lvl_head  [LEVEL_CNT];
  int                lvl_count [LEVEL_CNT];

  spmf_pkg::res_t pending_results[$];

  int n_added, n_dropped, n_popped, n_empty_pops, n_checked, n_errors;

  // idling controls
  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;
  int burst_left;
  int stall_run;
  bit stall_ready;

  // Highest level holding a word, -1 if none
  function automatic int highest_level();
    for (int lv = LEVEL_CNT - 1; lv >= 0; lv--) begin
      if (lvl_count[lv] != 0) return lv;
    end
    return -1;
  endfunction

  // Apply one request to the predicted queues, return the expected result
  function automatic spmf_pkg::res_t apply_request(logic op, logic [WORD_W-1:0] word,
                                                   logic [LVL_W-1:0] lvl);
    spmf_pkg::res_t r;
    int             top;
    r = '0;
    r.status = spmf_pkg::ST_OK;
    if (op == spmf_pkg::FUNC_ADD) begin
      if (int'(lvl) >= LEVEL_CNT || lvl_count[lvl] >= DEPTH) begin
        r.status = spmf_pkg::ST_FULL;
        n_dropped++;
      end else begin
        slot_word[int'(lvl)*DEPTH + (lvl_head[lvl] + lvl_count[lvl]) % DEPTH] = word;
        lvl_count[lvl]++;
        n_added++;
      end
    end else begin
      top = highest_level();
      if (top < 0) begin
        r.status = spmf_pkg::ST_EMPTY;
        n_empty_pops++;
      end else begin
        r.out_item = slot_word[top*DEPTH + lvl_head[top]];
        lvl_head[top] = (lvl_head[top] + 1) % DEPTH;
        lvl_count[top]--;
        n_popped++;
      end
    end
    top = highest_level();
    if (top < 0) begin
      r.all_empty = 1'b1;
    end else begin
      r.top_level = top[LVL_W-1:0];
      r.head_item = slot_word[top*DEPTH + lvl_head[top]];
    end
    return r;
  endfunction

  // Send one request; bursts of random length separated by random gaps
  task automatic send_request(logic op, logic [WORD_W-1:0] word, logic [LVL_W-1:0] lvl);
    int gap_len;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_len = gaps_on ? $urandom_range(0, 5) : 0;
      if (gap_len > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap_len - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {5'b0, lvl, word};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(apply_request(op, word, lvl));
    burst_left--;
  endtask

  // Result side: runs of ready and stall of random length
  always @(negedge clk) begin
    if (!stalls_on) begin
      m_tready <= 1'b1;
    end else begin
      if (stall_run == 0) begin
        stall_run   = $urandom_range(1, 8);
        stall_ready = ($urandom_range(0, 2) != 0);
      end
      stall_run--;
      m_tready <= stall_ready;
    end
  end

  task automatic check_field(string name, logic [WORD_W-1:0] exp_v, logic [WORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      n_errors++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    spmf_pkg::res_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h/%h",
                 $time, m_tuser, m_tdata);
        n_errors++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status",    WORD_W'(exp_r.status),    WORD_W'(m_tuser));
        check_field("out_item",  exp_r.out_item,           m_tdata[31:0]);
        check_field("top_level", WORD_W'(exp_r.top_level), WORD_W'(m_tdata[34:32]));
        check_field("head_item", exp_r.head_item,          m_tdata[66:35]);
        check_field("all_empty", WORD_W'(exp_r.all_empty), WORD_W'(m_tdata[67]));
        n_checked++;
      end
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Remove from an empty queue right after reset; item and level are ignored
  task automatic test_empty_remove();
    send_request(spmf_pkg::FUNC_REMOVE, '1, 3'd7);
  endtask

  // Extreme words at the lowest and highest level, then drain in priority order
  task automatic test_level_extremes();
    send_request(spmf_pkg::FUNC_ADD, '0, 3'd0);
    send_request(spmf_pkg::FUNC_ADD, '1, 3'd7);
    send_request(spmf_pkg::FUNC_REMOVE, '0, 3'd0);
    send_request(spmf_pkg::FUNC_REMOVE, '1, 3'd5);
  endtask

  // Fill one level to capacity, one more add must be dropped
  task automatic test_full_level();
    for (int i = 0; i <= DEPTH; i++) send_request(spmf_pkg::FUNC_ADD, rand_word(), 3'd3);
    send_request(spmf_pkg::FUNC_REMOVE, $urandom, 3'($urandom));
  endtask

  // Random traffic: add_pct sets the add share, half the adds pick one hot level, the rest a random level
  task automatic test_random_traffic(int n_items, int add_pct);
    logic [LVL_W-1:0] hot;
    logic [LVL_W-1:0] lvl;
    hot = 3'($urandom);
    for (int i = 0; i < n_items; i++) begin
      lvl = $urandom_range(0, 1) ? hot : 3'($urandom);
      if ($urandom_range(0, 99) < add_pct) send_request(spmf_pkg::FUNC_ADD, rand_word(), lvl);
      else send_request(spmf_pkg::FUNC_REMOVE, $urandom, 3'($urandom));
    end
  endtask

  initial begin
    foreach (lvl_count[i]) begin
      lvl_count[i] = 0;
      lvl_head[i]  = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_remove();
    test_level_extremes();
    test_full_level();

    // fill-heavy: levels run into their limit
    test_random_traffic(200, 75);
    // drain-heavy with no idling on either side
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    test_random_traffic(200, 25);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    test_random_traffic(200, 50);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d adds, %0d dropped adds, %0d removes, %0d removes on empty queue;",
             n_added, n_dropped, n_popped, n_empty_pops);
    $display("%0d results compared, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("PASS strict_priority_multi_fifo");
    end else begin
      $display("FAIL strict_priority_multi_fifo");
    end
    $finish;
  end

  // Run limit
  initial begin
    #500000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("FAIL strict_priority_multi_fifo");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/spmf_pkg.sv
rtl/spmf_ram.sv
rtl/spmf_front.sv
rtl/spmf_back.sv
rtl/strict_priority_multi_fifo.sv
sim/tb.sv
